// ----- hw/rtl/rne_pkg.sv -----
// rne_pkg: shared types, constants and the microcode table for the roman numeral encoder.
// No dependencies. Used by every module of the block.
package rne_pkg;

  localparam int ValueW = 12;
  localparam int CharW  = 7;
  localparam int PcW    = 5;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CharW-1:0]  char_t;
  typedef logic [PcW-1:0]    pc_t;

  localparam value_t ValueMax = 12'd3999;

  localparam char_t ChM  = 7'h4D;
  localparam char_t ChD  = 7'h44;
  localparam char_t ChC  = 7'h43;
  localparam char_t ChL  = 7'h4C;
  localparam char_t ChX  = 7'h58;
  localparam char_t ChV  = 7'h56;
  localparam char_t ChI  = 7'h49;
  localparam char_t ChNl = 7'h0A;

  localparam pc_t PcStart   = 5'd0;
  localparam pc_t PcNewline = 5'd19;

  // one control word: emit chr when remainder >= thr, then go to hit_pc, else go to miss_pc
  typedef struct packed {
    value_t thr;
    char_t  chr;
    logic   sub;
    logic   last;
    pc_t    hit_pc;
    pc_t    miss_pc;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic   load;
    logic   emit;
    logic   sub;
    logic   last;
    logic   bad;
    value_t thr;
    char_t  chr;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic ge;
    logic out_free;
  } sts_t;

  function automatic uword_t mk(value_t thr, char_t chr, logic sub, logic last,
                                pc_t hit_pc, pc_t miss_pc);
    uword_t w;
    w.thr     = thr;
    w.chr     = chr;
    w.sub     = sub;
    w.last    = last;
    w.hit_pc  = hit_pc;
    w.miss_pc = miss_pc;
    return w;
  endfunction

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = mk(12'd1000, ChM, 1'b1, 1'b0, 5'd0,  5'd1);
      5'd1:    w = mk(12'd900,  ChC, 1'b0, 1'b0, 5'd2,  5'd3);
      5'd2:    w = mk(12'd900,  ChM, 1'b1, 1'b0, 5'd3,  5'd3);
      5'd3:    w = mk(12'd500,  ChD, 1'b1, 1'b0, 5'd4,  5'd4);
      5'd4:    w = mk(12'd400,  ChC, 1'b0, 1'b0, 5'd5,  5'd6);
      5'd5:    w = mk(12'd400,  ChD, 1'b1, 1'b0, 5'd6,  5'd6);
      5'd6:    w = mk(12'd100,  ChC, 1'b1, 1'b0, 5'd6,  5'd7);
      5'd7:    w = mk(12'd90,   ChX, 1'b0, 1'b0, 5'd8,  5'd9);
      5'd8:    w = mk(12'd90,   ChC, 1'b1, 1'b0, 5'd9,  5'd9);
      5'd9:    w = mk(12'd50,   ChL, 1'b1, 1'b0, 5'd10, 5'd10);
      5'd10:   w = mk(12'd40,   ChX, 1'b0, 1'b0, 5'd11, 5'd12);
      5'd11:   w = mk(12'd40,   ChL, 1'b1, 1'b0, 5'd12, 5'd12);
      5'd12:   w = mk(12'd10,   ChX, 1'b1, 1'b0, 5'd12, 5'd13);
      5'd13:   w = mk(12'd9,    ChI, 1'b0, 1'b0, 5'd14, 5'd15);
      5'd14:   w = mk(12'd9,    ChX, 1'b1, 1'b0, 5'd15, 5'd15);
      5'd15:   w = mk(12'd5,    ChV, 1'b1, 1'b0, 5'd16, 5'd16);
      5'd16:   w = mk(12'd4,    ChI, 1'b0, 1'b0, 5'd17, 5'd18);
      5'd17:   w = mk(12'd4,    ChV, 1'b1, 1'b0, 5'd18, 5'd18);
      5'd18:   w = mk(12'd1,    ChI, 1'b1, 1'b0, 5'd18, 5'd19);
      default: w = mk(12'd0,    ChNl, 1'b0, 1'b1, PcNewline, PcNewline);
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/roman_numeral_encoder.sv -----
// roman_numeral_encoder: top level, a microcoded sequencer over a compare/subtract datapath.
// Depends on rne_pkg, rne_seq and rne_dp.
//
// Input channel: value_i with in_valid_i / in_ready_o. One item is one number, 0 to 3999.
// Output channel: char_code_o, last_o, out_of_range_o with out_valid_o / out_ready_i.
// Each item gives a run of ASCII letters (M D C L X V I) ended by a newline that has
// last_o set. Zero gives the newline alone. A value above 3999 gives one newline with
// out_of_range_o set.
// The sequencer walks a 20-step table of thresholds (1000, 900, 500 ... 1). A step that
// matches emits one letter; a step that does not match gives no letter. An out-of-range
// item goes straight to the newline step. A character shows on the outputs the cycle
// after its step. The next item can be taken in the cycle after the newline is emitted.
// in_ready_o is high while no item is in work; the next item can be taken while the
// newline of the previous one still waits in the output register.
// When the receiver stalls, a matching step holds until the output register frees.
// Reset clears the sequencer and the output valid; the block comes up ready.
module roman_numeral_encoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rne_pkg::value_t value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rne_pkg::char_t  char_code_o,
  output logic            last_o,
  output logic            out_of_range_o
);
  import rne_pkg::*;

  ctrl_t ctrl;
  sts_t  sts;

  rne_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .sts_i      (sts),
    .ctrl_o     (ctrl)
  );

  rne_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .ctrl_i         (ctrl),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_code_o    (char_code_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

// ----- hw/rtl/rne_seq.sv -----
// rne_seq: step counter and microcode fetch with conditional jumps.
// Depends on rne_pkg; drives rne_dp through ctrl_t.
module rne_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rne_pkg::value_t value_i,
  input  rne_pkg::sts_t   sts_i,
  output rne_pkg::ctrl_t  ctrl_o
);
  import rne_pkg::*;

  logic   busy_q, busy_d;
  logic   bad_q, bad_d;
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   accept, emit, adv, in_bad;

  assign uw         = ucode(pc_q);
  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign in_bad     = value_i > ValueMax;
  assign emit       = busy_q && sts_i.ge && sts_i.out_free;
  assign adv        = busy_q && (!sts_i.ge || sts_i.out_free);

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    bad_d  = bad_q;
    if (accept) begin
      pc_d   = in_bad ? PcNewline : PcStart;
      busy_d = 1'b1;
      bad_d  = in_bad;
    end else begin
      if (adv) begin
        pc_d = sts_i.ge ? uw.hit_pc : uw.miss_pc;
      end
      if (emit && uw.last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
      pc_q   <= PcStart;
    end else begin
      busy_q <= busy_d;
      bad_q  <= bad_d;
      pc_q   <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.load = accept;
    ctrl_o.emit = emit;
    ctrl_o.sub  = uw.sub;
    ctrl_o.last = uw.last;
    ctrl_o.bad  = bad_q;
    ctrl_o.thr  = uw.thr;
    ctrl_o.chr  = uw.chr;
  end

endmodule

// ----- hw/rtl/rne_dp.sv -----
// rne_dp: remainder register, compare and subtract, and the output register.
// Depends on rne_pkg; controlled by rne_seq.
module rne_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rne_pkg::value_t value_i,
  input  rne_pkg::ctrl_t  ctrl_i,
  output rne_pkg::sts_t   sts_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rne_pkg::char_t  char_code_o,
  output logic            last_o,
  output logic            out_of_range_o
);
  import rne_pkg::*;

  value_t rem_q, rem_d;
  logic   out_valid_q, out_valid_d;
  char_t  char_q, char_d;
  logic   last_q, last_d;
  logic   oor_q, oor_d;

  assign sts_o.ge       = rem_q >= ctrl_i.thr;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    rem_d = rem_q;
    if (ctrl_i.load) begin
      rem_d = value_i;
    end else if (ctrl_i.emit && ctrl_i.sub) begin
      rem_d = rem_q - ctrl_i.thr;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    oor_d       = oor_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
      char_d      = ctrl_i.chr;
      last_d      = ctrl_i.last;
      oor_d       = ctrl_i.last && ctrl_i.bad;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
    oor_q  <= oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign char_code_o    = char_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;

endmodule

// ----- hw/rtl/rne_checker.sv -----
// rne_checker: port-level assertions for roman_numeral_encoder, bound to the top level.
// Depends on rne_pkg and roman_numeral_encoder.
module rne_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input rne_pkg::char_t  char_code_o,
  input logic            last_o,
  input logic            out_of_range_o
);
  import rne_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o)
      && $stable(last_o) && $stable(out_of_range_o))
    else $error("output item changed while stalled");

  a_oor_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> last_o && char_code_o == ChNl)
    else $error("out of range flag off the ending newline");

  a_last_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (char_code_o == ChNl)))
    else $error("last flag and newline disagree");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again right after an item was taken");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);

// ----- sim/roman_numeral_encoder_test.sv -----
// roman_numeral_encoder_test: self-checking bench for the roman numeral encoder.
// Drives numbers over valid/ready, predicts each character run and checks it in order.
// Depends on rne_pkg and roman_numeral_encoder.
module roman_numeral_encoder_test;
  import rne_pkg::*;

  localparam int NumDir     = 22;
  localparam int NumRandom  = 500;
  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 40;
  localparam int IdlePct    = 24;

  typedef struct packed {
    char_t code;
    logic  last;
    logic  bad;
  } char_rec_t;

  typedef struct packed {
    value_t    value;
    logic      typed;
    char_rec_t want;
  } numeral_item_t;

  localparam char_rec_t NoWant  = '0;
  localparam char_rec_t NlGood  = '{ChNl, 1'b1, 1'b0};
  localparam char_rec_t NlBad   = '{ChNl, 1'b1, 1'b1};

  localparam numeral_item_t DirTable [NumDir] = '{
    '{12'd0,    1'b1, NlGood},
    '{12'd3999, 1'b0, NoWant},
    '{12'd4000, 1'b1, NlBad},
    '{12'd4095, 1'b1, NlBad},
    '{12'd3888, 1'b0, NoWant},
    '{12'd1,    1'b0, NoWant},
    '{12'd4,    1'b0, NoWant},
    '{12'd5,    1'b0, NoWant},
    '{12'd9,    1'b0, NoWant},
    '{12'd14,   1'b0, NoWant},
    '{12'd40,   1'b0, NoWant},
    '{12'd49,   1'b0, NoWant},
    '{12'd90,   1'b0, NoWant},
    '{12'd400,  1'b0, NoWant},
    '{12'd444,  1'b0, NoWant},
    '{12'd900,  1'b0, NoWant},
    '{12'd1000, 1'b0, NoWant},
    '{12'd2048, 1'b0, NoWant},
    '{12'd3000, 1'b0, NoWant},
    '{12'd1994, 1'b0, NoWant},
    '{12'd2767, 1'b0, NoWant},
    '{12'd3333, 1'b0, NoWant}
  };

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  value_t value_i     = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  char_t  char_code_o;
  logic   last_o;
  logic   out_of_range_o;

  numeral_item_t stim_q [$];
  numeral_item_t cur_item = '0;
  char_rec_t     char_q [$];
  int            n_taken  = 0;
  int            n_errors = 0;
  logic          quiet;

  roman_numeral_encoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_code_o    (char_code_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

  // no idling on either side for a stretch of the random items
  assign quiet = (n_taken >= 250) && (n_taken < 350);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_char(char_t code, logic last, logic bad);
    char_rec_t rec;
    rec.code = code;
    rec.last = last;
    rec.bad  = bad;
    char_q.push_back(rec);
  endfunction

  function automatic void expand_digit(int digit, char_t one, char_t five, char_t ten);
    if (digit <= 3) begin
      for (int k = 0; k < digit; k++) push_char(one, 1'b0, 1'b0);
    end else if (digit == 4) begin
      push_char(one, 1'b0, 1'b0);
      push_char(five, 1'b0, 1'b0);
    end else if (digit <= 8) begin
      push_char(five, 1'b0, 1'b0);
      for (int k = 5; k < digit; k++) push_char(one, 1'b0, 1'b0);
    end else begin
      push_char(one, 1'b0, 1'b0);
      push_char(ten, 1'b0, 1'b0);
    end
  endfunction

  function automatic void expand_numeral(value_t value);
    int v;
    v = int'(value);
    if (v > 3999) begin
      push_char(ChNl, 1'b1, 1'b1);
    end else begin
      for (int k = 0; k < v / 1000; k++) push_char(ChM, 1'b0, 1'b0);
      expand_digit((v / 100) % 10, ChC, ChD, ChM);
      expand_digit((v / 10) % 10, ChX, ChL, ChC);
      expand_digit(v % 10, ChI, ChV, ChX);
      push_char(ChNl, 1'b1, 1'b0);
    end
  endfunction

  function automatic value_t random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return value_t'(4000 + $urandom_range(95));
    end else if (pick < 25) begin
      // long runs: high digits in the hundreds, tens and ones positions
      return value_t'($urandom_range(3) * 1000 + $urandom_range(9, 5) * 100 +
                      $urandom_range(9, 5) * 10 + $urandom_range(9, 5));
    end else begin
      return value_t'($urandom_range(3999));
    end
  endfunction

  // input side: sample acceptance and drive the next item on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (cur_item.typed) char_q.push_back(cur_item.want);
        else expand_numeral(cur_item.value);
        n_taken <= n_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (stim_q.size() != 0 && (quiet || $urandom_range(99) >= IdlePct)) begin
          cur_item = stim_q.pop_front();
          value_i    <= cur_item.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (char_q.size() == 0) begin
          $display("%0t unexpected item: char_code %h last %b out_of_range %b",
                   $time, char_code_o, last_o, out_of_range_o);
          n_errors++;
        end else begin
          char_rec_t want;
          want = char_q.pop_front();
          if (char_code_o !== want.code) begin
            $display("%0t char_code expected %h actual %h", $time, want.code, char_code_o);
            n_errors++;
          end
          if (last_o !== want.last) begin
            $display("%0t last expected %b actual %b", $time, want.last, last_o);
            n_errors++;
          end
          if (out_of_range_o !== want.bad) begin
            $display("%0t out_of_range expected %b actual %b", $time, want.bad,
                     out_of_range_o);
            n_errors++;
          end
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    numeral_item_t item;
    for (int i = 0; i < NumDir; i++) stim_q.push_back(DirTable[i]);
    for (int i = 0; i < NumRandom; i++) begin
      item       = '0;
      item.value = random_value();
      stim_q.push_back(item);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || char_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (char_q.size() != 0) begin
      $display("%0t %0d expected items never arrived", $time, char_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
